// ===== hw/rtl/knxfb_pkg.sv =====
// Shared types and constants for the twisted-pair frame builder.
package knxfb_pkg;

	localparam int unsigned MaxPayloadDefault = 16;
	localparam int unsigned CmdDepth = 2;

	localparam logic [7:0] CtrlBase = 8'h30;
	localparam logic [7:0] CtrlPrioMask = 8'h0C;
	localparam logic [7:0] CtrlFmtMask = 8'h80;
	localparam logic [2:0] HopCountReset = 3'd6;

	localparam logic [2:0] StepCtrl = 3'd0;
	localparam logic [2:0] StepSrcHi = 3'd1;
	localparam logic [2:0] StepSrcLo = 3'd2;
	localparam logic [2:0] StepDstHi = 3'd3;
	localparam logic [2:0] StepDstLo = 3'd4;
	localparam logic [2:0] StepRoute = 3'd5;
	localparam logic [2:0] StepData = 3'd6;
	localparam logic [2:0] StepCheck = 3'd7;

	localparam logic RegHopCount = 1'b0;

	typedef struct packed {
		logic        first;
		logic        last;
		logic [1:0]  prio;
		logic        fmt;
		logic        addr_type;
		logic [15:0] src;
		logic [15:0] dst;
		logic [3:0]  len_nib;
		logic [7:0]  data;
	} cmd_t;

endpackage

// ===== hw/rtl/knx_tp_frame_builder.sv =====
// Top level of the twisted-pair standard frame builder.
// Push payload bytes in; the first byte of a frame samples the header fields and yields six
// header bytes plus the byte itself, later bytes yield one byte each, and the last byte of a
// frame adds the inverted XOR check byte (last_of_frame high). The result side delivers one
// byte per cycle while the reader keeps popping, from a single output register that the
// byte sequencer in the back end fills. A two-entry command queue lets input bytes be taken
// while the sequencer works. The hop limit sits at byte address 0 of the configuration port.
module knx_tp_frame_builder #(
	parameter int unsigned MAX_PAYLOAD = knxfb_pkg::MaxPayloadDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  priority_req,
	input  logic        frame_fmt,
	input  logic        addr_group,
	input  logic [15:0] src_addr,
	input  logic [15:0] dst_addr,
	input  logic [4:0]  payload_length,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  frame_byte,
	output logic        last_of_frame
);

	logic [2:0]      hop_q;
	logic            accept;
	knxfb_pkg::cmd_t front_cmd;
	knxfb_pkg::cmd_t head_cmd;
	logic            cq_empty;
	logic            cq_pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == knxfb_pkg::RegHopCount) ? {29'd0, hop_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q <= knxfb_pkg::HopCountReset;
		end else if (psel && penable && pwrite && paddr[2] == knxfb_pkg::RegHopCount) begin
			hop_q <= pwdata[2:0];
		end
	end

	assign accept = push && !full;

	knxfb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.priority_req  (priority_req),
		.frame_fmt     (frame_fmt),
		.addr_group    (addr_group),
		.src_addr      (src_addr),
		.dst_addr      (dst_addr),
		.payload_length(payload_length),
		.data_byte     (data_byte),
		.cmd           (front_cmd)
	);

	knxfb_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(front_cmd),
		.full   (full),
		.rd_en  (cq_pop),
		.rd_data(head_cmd),
		.empty  (cq_empty)
	);

	knxfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.hop_limit    (hop_q),
		.cmd          (head_cmd),
		.cmd_empty    (cq_empty),
		.cmd_pop      (cq_pop),
		.frame_byte   (frame_byte),
		.last_of_frame(last_of_frame),
		.empty        (empty),
		.pop          (pop)
	);

endmodule

// ===== hw/rtl/knxfb_front.sv =====
// Front end: tracks frame position, clamps the length and classifies each byte.
module knxfb_front #(
	parameter int unsigned MAX_PAYLOAD = knxfb_pkg::MaxPayloadDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          priority_req,
	input  logic                frame_fmt,
	input  logic                addr_group,
	input  logic [15:0]         src_addr,
	input  logic [15:0]         dst_addr,
	input  logic [4:0]          payload_length,
	input  logic [7:0]          data_byte,
	output knxfb_pkg::cmd_t     cmd
);

	localparam logic [4:0] MaxLen = 5'(MAX_PAYLOAD);

	logic [4:0] pos_q;
	logic [4:0] len_q;
	logic [4:0] clamp_len;
	logic [4:0] cur_len;
	logic [4:0] pos_next;
	logic [4:0] len_m1;
	logic       first;
	logic       last;

	always_comb begin
		if (payload_length == 5'd0) begin
			clamp_len = 5'd1;
		end else if (payload_length > MaxLen) begin
			clamp_len = MaxLen;
		end else begin
			clamp_len = payload_length;
		end
	end

	assign first    = (pos_q == 5'd0);
	assign cur_len  = first ? clamp_len : len_q;
	assign pos_next = pos_q + 5'd1;
	assign last     = (pos_next >= cur_len);
	assign len_m1   = clamp_len - 5'd1;

	always_comb begin
		cmd.first     = first;
		cmd.last      = last;
		cmd.prio      = priority_req;
		cmd.fmt       = frame_fmt;
		cmd.addr_type = addr_group;
		cmd.src       = src_addr;
		cmd.dst       = dst_addr;
		cmd.len_nib   = len_m1[3:0];
		cmd.data      = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 5'd0;
			len_q <= 5'd0;
		end else if (accept) begin
			len_q <= cur_len;
			pos_q <= last ? 5'd0 : pos_next;
		end
	end

endmodule

// ===== hw/rtl/knxfb_cmd_queue.sv =====
// Short command queue between the front end and the byte sequencer.
module knxfb_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  knxfb_pkg::cmd_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output knxfb_pkg::cmd_t rd_data,
	output logic            empty
);

	localparam int unsigned Depth = knxfb_pkg::CmdDepth;
	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	knxfb_pkg::cmd_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/knxfb_back.sv =====
// Back end: steps through header, data and check bytes into the result register.
module knxfb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      hop_limit,
	input  knxfb_pkg::cmd_t cmd,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	output logic [7:0]      frame_byte,
	output logic            last_of_frame,
	output logic            empty,
	input  logic            pop
);

	logic [2:0] step_q;
	logic [7:0] xor_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic [2:0] eff_step;
	logic [7:0] cur_byte;
	logic       slot_free;
	logic       emit;
	logic       done;

	assign slot_free = !out_valid_q || pop;
	assign emit      = !cmd_empty && slot_free;
	assign eff_step  = (!cmd.first && step_q == knxfb_pkg::StepCtrl) ?
		knxfb_pkg::StepData : step_q;
	assign done      = (eff_step == knxfb_pkg::StepCheck) ||
		(eff_step == knxfb_pkg::StepData && !cmd.last);
	assign cmd_pop   = emit && done;

	always_comb begin
		case (eff_step)
			knxfb_pkg::StepCtrl: cur_byte = knxfb_pkg::CtrlBase |
				({4'd0, cmd.prio, 2'd0} & knxfb_pkg::CtrlPrioMask) |
				({cmd.fmt, 7'd0} & knxfb_pkg::CtrlFmtMask);
			knxfb_pkg::StepSrcHi: cur_byte = cmd.src[15:8];
			knxfb_pkg::StepSrcLo: cur_byte = cmd.src[7:0];
			knxfb_pkg::StepDstHi: cur_byte = cmd.dst[15:8];
			knxfb_pkg::StepDstLo: cur_byte = cmd.dst[7:0];
			knxfb_pkg::StepRoute: cur_byte = {cmd.addr_type, hop_limit, cmd.len_nib};
			knxfb_pkg::StepData:  cur_byte = cmd.data;
			knxfb_pkg::StepCheck: cur_byte = ~xor_q;
			default:              cur_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= knxfb_pkg::StepCtrl;
			xor_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				step_q      <= done ? knxfb_pkg::StepCtrl : eff_step + 3'd1;
				if (eff_step == knxfb_pkg::StepCtrl) begin
					xor_q <= cur_byte;
				end else if (eff_step != knxfb_pkg::StepCheck) begin
					xor_q <= xor_q ^ cur_byte;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= (eff_step == knxfb_pkg::StepCheck);
		end
	end

	assign frame_byte    = out_byte_q;
	assign last_of_frame = out_last_q;
	assign empty         = !out_valid_q;

endmodule
